FILE: rtl/rco_pkg.sv
// Package for the rose curve oscillator: sequencer states, register indexes and helpers.
package rco_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXPI,
    ST_INC,
    ST_PLO,
    ST_PHI,
    ST_DIV,
    ST_PHASE,
    ST_SIN_SET,
    ST_SIN_MUL,
    ST_R29,
    ST_XY,
    ST_BQ,
    ST_OUT
  } state_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_B0   = 3'd1;
  localparam logic [2:0] REG_B1   = 3'd2;
  localparam logic [2:0] REG_B2   = 3'd3;
  localparam logic [2:0] REG_A1   = 3'd4;
  localparam logic [2:0] REG_A2   = 3'd5;

  // Width of the petal product before the division.
  localparam int NUM_W = 62;

  // Exponent table, 2^(k/16) in Q16.
  function automatic logic [17:0] exp_entry(input logic [4:0] k);
    logic [17:0] e;
    case (k)
      5'd0:    e = 18'd65536;
      5'd1:    e = 18'd68438;
      5'd2:    e = 18'd71468;
      5'd3:    e = 18'd74632;
      5'd4:    e = 18'd77936;
      5'd5:    e = 18'd81386;
      5'd6:    e = 18'd84990;
      5'd7:    e = 18'd88752;
      5'd8:    e = 18'd92682;
      5'd9:    e = 18'd96785;
      5'd10:   e = 18'd101070;
      5'd11:   e = 18'd105545;
      5'd12:   e = 18'd110218;
      5'd13:   e = 18'd115098;
      5'd14:   e = 18'd120194;
      5'd15:   e = 18'd125515;
      default: e = 18'd131072;
    endcase
    return e;
  endfunction

  // Offsets of the Horner steps of the quarter sine polynomial.
  function automatic logic [30:0] poly_const(input logic [5:0] step);
    logic [30:0] c;
    case (step)
      6'd1:    c = 31'd5026995;
      6'd2:    c = 31'd85569306;
      6'd3:    c = 31'd693598668;
      default: c = 31'd1686629713;
    endcase
    return c;
  endfunction

  // Rounding right shift, ties toward plus infinity.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Saturation to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturation to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/rose_curve_oscillator.sv
// Rose curve oscillator: phase accumulators, sine evaluation and two highpass biquads.
//
//  channel   direction  tdata fields (low bit up)                         transfer when
//  s_axis    in         pitch_octaves, ratio_numerator, ratio_denominator,  tvalid & tready
//                       blend, rotation (16 bits each)
//  m_axis    out        x_out, y_out (16 bits each)                         tvalid & tready
//  cfg       in         cfg_index selects register, cfg_data holds value    cfg_write
//
// After an input transfer the block is busy until the result is registered, and it accepts no
// new sample in that time. The time is set by the single shared 33x33 multiplier (35 products)
// and the 62 step bit serial divider for the petal increment. The sine of each angle is
// evaluated on the multiplier, three per sample. Reset clears the phases and filter state and
// sets the configuration registers to their defaults. A finished result waits in the output
// register; the next sample is accepted then, and the block holds in its last step if the
// earlier result is still not taken.
module rose_curve_oscillator #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pitch_octaves, ratio_numerator, ratio_denominator, blend, rotation
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // x_out, y_out
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int PB = PHASE_BITS;
  localparam int SB = SINE_TABLE_BITS;
  localparam int QB = SB - 2;
  localparam int RS = (PB < 40) ? 40 - PB : 0;
  localparam int LS = (PB >= 40) ? PB - 40 : 0;
  localparam int NW = rco_pkg::NUM_W;

  // Control state.
  rco_pkg::state_t state, state_next;
  logic [5:0] step, step_next;
  logic       half, half_next;
  logic [1:0] which, which_next;
  logic       ch, ch_next;

  // Configuration registers.
  logic [31:0]        base_increment;
  logic signed [23:0] hp_b0, hp_b1, hp_b2, hp_a1, hp_a2;

  // Clamped sample fields.
  logic [15:0] p_q, n_q, d_q;
  logic [14:0] a_q, rot_q;

  // Datapath registers.
  logic [17:0]           m_q;
  logic [45:0]           inc40;
  logic signed [63:0]    prod, acc;
  logic [NW-1:0]         num;
  logic [16:0]           rem;
  logic [PB-1:0]         main_phase, petal_phase;
  logic [30:0]           u_q, u2_q, t_q;
  logic                  neg_q;
  logic signed [15:0]    sval;
  logic signed [31:0]    r29, xin, yin, yv;
  logic signed [31:0]    mem0 [2];
  logic signed [31:0]    mem1 [2];
  logic signed [15:0]    xo, yo;
  logic                  out_valid;
  logic [31:0]           out_data;

  logic s_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == rco_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Input clamping.
  logic signed [16:0] pitch_e;
  logic signed [15:0] blend_s, rot_s;
  logic [15:0]        n_raw, d_raw, p_cl, n_cl, d_cl;
  logic [14:0]        a_cl, rot_cl;
  always_comb begin
    pitch_e = {s_axis_tdata[15], s_axis_tdata[15:0]};
    n_raw   = s_axis_tdata[31:16];
    d_raw   = s_axis_tdata[47:32];
    blend_s = s_axis_tdata[63:48];
    rot_s   = s_axis_tdata[79:64];
    if (pitch_e < -17'sd16384) begin
      p_cl = 16'd0;
    end else if (pitch_e > 17'sd16384) begin
      p_cl = 16'd32768;
    end else begin
      p_cl = 16'(pitch_e + 17'sd16384);
    end
    n_cl   = (n_raw < 16'd4096) ? 16'd4096 : ((n_raw > 16'd40960) ? 16'd40960 : n_raw);
    d_cl   = (d_raw < 16'd4096) ? 16'd4096 : ((d_raw > 16'd40960) ? 16'd40960 : d_raw);
    a_cl   = (blend_s < 16'sd0) ? 15'd0 :
             ((blend_s > 16'sd16384) ? 15'd16384 : blend_s[14:0]);
    rot_cl = (rot_s < 16'sd0) ? 15'd0 :
             ((rot_s > 16'sd16384) ? 15'd16384 : rot_s[14:0]);
  end

  // Angle and sine table address.
  logic [PB-1:0] theta, ang, ph_sel, quarter;
  logic [SB-1:0] idx;
  logic [1:0]    quad;
  logic [30:0]   u0, u_set;
  always_comb begin
    quarter = PB'(1) << (PB - 2);
    theta   = PB'(rot_q) << (PB - 14);
    ang     = main_phase + theta;
    case (which)
      2'd0:    ph_sel = petal_phase + quarter;
      2'd1:    ph_sel = ang + quarter;
      default: ph_sel = ang;
    endcase
    idx   = ph_sel[PB-1 -: SB];
    quad  = idx[SB-1 -: 2];
    u0    = 31'(idx[QB-1:0]) << (30 - QB);
    u_set = quad[0] ? (31'(1) << 30) - u0 : u0;
  end

  // Exponent lookup and phase steps.
  logic [4:0]    k_idx;
  logic [17:0]   e_lo, e_hi;
  logic [63:0]   inc_sh, main_step64, petal_step64;
  always_comb begin
    k_idx        = {1'b0, p_q[11:8]};
    e_lo         = rco_pkg::exp_entry(k_idx);
    e_hi         = rco_pkg::exp_entry(k_idx + 5'd1);
    inc_sh       = (64'(prod) << p_q[15:12]) >> 12;
    main_step64  = (64'(inc40) >> RS) << LS;
    petal_step64 = (64'(num) >> RS) << LS;
  end

  // Shared multiplier operand selection.
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      rco_pkg::ST_EXPI: begin
        mul_a = 33'(e_hi - e_lo);
        mul_b = 33'(p_q[7:0]);
      end
      rco_pkg::ST_INC: begin
        mul_a = {1'b0, base_increment};
        mul_b = 33'(m_q);
      end
      rco_pkg::ST_PLO: begin
        mul_a = {1'b0, inc40[31:0]};
        mul_b = 33'(n_q);
      end
      rco_pkg::ST_PHI: begin
        mul_a = 33'(inc40[45:32]);
        mul_b = 33'(n_q);
      end
      rco_pkg::ST_SIN_MUL: begin
        if (step == 6'd0) begin
          mul_a = 33'(u_q);
          mul_b = 33'(u_q);
        end else if (step == 6'd1) begin
          mul_a = 33'(u2_q);
          mul_b = 33'd172273;
        end else if (step == 6'd5) begin
          mul_a = 33'(u_q);
          mul_b = 33'(t_q);
        end else begin
          mul_a = 33'(u2_q);
          mul_b = 33'(t_q);
        end
      end
      rco_pkg::ST_R29: begin
        mul_a = 33'(15'd16384 - a_q);
        mul_b = 33'(sval);
      end
      rco_pkg::ST_XY: begin
        mul_a = 33'(r29);
        mul_b = 33'(sval);
      end
      rco_pkg::ST_BQ: begin
        mul_a = (step == 6'd2 || step == 6'd4) ? 33'(yv) : (ch ? 33'(yin) : 33'(xin));
        case (step)
          6'd0:    mul_b = 33'(hp_b0);
          6'd1:    mul_b = 33'(hp_b1);
          6'd2:    mul_b = 33'(hp_a1);
          6'd3:    mul_b = 33'(hp_b2);
          default: mul_b = 33'(hp_a2);
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rco_pkg::ST_IDLE;
      step  <= '0;
      half  <= 1'b0;
      which <= '0;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      half  <= half_next;
      which <= which_next;
      ch    <= ch_next;
    end
  end

  // Next state: each multiplier step is an issue half followed by an apply half.
  logic out_free;
  assign out_free = !out_valid || m_axis_tready;
  always_comb begin
    state_next = state;
    step_next  = step;
    half_next  = half;
    which_next = which;
    ch_next    = ch;
    unique case (state)
      rco_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_next = rco_pkg::ST_EXPI;
          half_next  = 1'b0;
        end
      end
      rco_pkg::ST_EXPI, rco_pkg::ST_INC, rco_pkg::ST_PLO, rco_pkg::ST_PHI: begin
        half_next = !half;
        if (half) begin
          unique case (state)
            rco_pkg::ST_EXPI: state_next = rco_pkg::ST_INC;
            rco_pkg::ST_INC:  state_next = rco_pkg::ST_PLO;
            rco_pkg::ST_PLO:  state_next = rco_pkg::ST_PHI;
            default: begin
              state_next = rco_pkg::ST_DIV;
              step_next  = '0;
            end
          endcase
        end
      end
      rco_pkg::ST_DIV: begin
        if (step == 6'(NW - 1)) begin
          state_next = rco_pkg::ST_PHASE;
        end else begin
          step_next = step + 6'd1;
        end
      end
      rco_pkg::ST_PHASE: begin
        state_next = rco_pkg::ST_SIN_SET;
        which_next = 2'd0;
      end
      rco_pkg::ST_SIN_SET: begin
        state_next = rco_pkg::ST_SIN_MUL;
        step_next  = '0;
        half_next  = 1'b0;
      end
      rco_pkg::ST_SIN_MUL: begin
        half_next = !half;
        if (half) begin
          if (step == 6'd5) begin
            state_next = (which == 2'd0) ? rco_pkg::ST_R29 : rco_pkg::ST_XY;
          end else begin
            step_next = step + 6'd1;
          end
        end
      end
      rco_pkg::ST_R29: begin
        half_next = !half;
        if (half) begin
          state_next = rco_pkg::ST_SIN_SET;
          which_next = 2'd1;
        end
      end
      rco_pkg::ST_XY: begin
        half_next = !half;
        if (half) begin
          if (which == 2'd1) begin
            state_next = rco_pkg::ST_SIN_SET;
            which_next = 2'd2;
          end else begin
            state_next = rco_pkg::ST_BQ;
            step_next  = '0;
            ch_next    = 1'b0;
          end
        end
      end
      rco_pkg::ST_BQ: begin
        half_next = !half;
        if (half) begin
          if (step == 6'd4) begin
            step_next = '0;
            if (ch) begin
              state_next = rco_pkg::ST_OUT;
            end else begin
              ch_next = 1'b1;
            end
          end else begin
            step_next = step + 6'd1;
          end
        end
      end
      rco_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = rco_pkg::ST_IDLE;
        end
      end
      default: state_next = rco_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_increment <= 32'd23409847;
      hp_b0          <= 24'sd4194304;
      hp_b1          <= '0;
      hp_b2          <= '0;
      hp_a1          <= '0;
      hp_a2          <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rco_pkg::REG_BASE: base_increment <= cfg_data;
        rco_pkg::REG_B0:   hp_b0          <= cfg_data[23:0];
        rco_pkg::REG_B1:   hp_b1          <= cfg_data[23:0];
        rco_pkg::REG_B2:   hp_b2          <= cfg_data[23:0];
        rco_pkg::REG_A1:   hp_a1          <= cfg_data[23:0];
        rco_pkg::REG_A2:   hp_a2          <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Output register holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rco_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rco_pkg::ST_OUT && out_free) begin
      out_data <= {yo, xo};
    end
  end

  // Phase accumulators and filter state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase  <= '0;
      petal_phase <= '0;
      mem0[0]     <= '0;
      mem0[1]     <= '0;
      mem1[0]     <= '0;
      mem1[1]     <= '0;
    end else if (state == rco_pkg::ST_PHASE) begin
      main_phase  <= main_phase + main_step64[PB-1:0];
      petal_phase <= petal_phase + petal_step64[PB-1:0];
    end else if (state == rco_pkg::ST_BQ && half) begin
      if (step == 6'd2) begin
        mem0[ch] <= rco_pkg::sat32(rco_pkg::rshr(acc - prod, 22));
      end else if (step == 6'd4) begin
        mem1[ch] <= rco_pkg::sat32(rco_pkg::rshr(acc - prod, 22));
      end
    end
  end

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // Datapath results of each step.
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic signed [63:0] sin_round;
  logic [15:0]        sin_mag;
  always_comb begin
    rem_sh    = {rem[15:0], num[NW-1]};
    rem_ge    = (rem_sh >= 17'(d_q));
    sin_round = ((prod >>> 30) + 64'sd16384) >>> 15;
    sin_mag   = (sin_round > 64'sd32767) ? 16'd32767 : sin_round[15:0];
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      p_q   <= p_cl;
      n_q   <= n_cl;
      d_q   <= d_cl;
      a_q   <= a_cl;
      rot_q <= rot_cl;
    end
    if (state == rco_pkg::ST_DIV) begin
      num <= {num[NW-2:0], rem_ge};
      rem <= rem_ge ? rem_sh - 17'(d_q) : rem_sh;
    end
    if (state == rco_pkg::ST_SIN_SET) begin
      u_q   <= u_set;
      neg_q <= quad[1];
    end
    if (half) begin
      case (state)
        rco_pkg::ST_EXPI: m_q   <= e_lo + 18'(prod >>> 8);
        rco_pkg::ST_INC:  inc40 <= inc_sh[45:0];
        rco_pkg::ST_PLO:  acc   <= prod;
        rco_pkg::ST_PHI: begin
          num <= NW'(acc + (prod <<< 32));
          rem <= '0;
        end
        rco_pkg::ST_SIN_MUL: begin
          if (step == 6'd0) begin
            u2_q <= 31'(prod >>> 30);
          end else if (step == 6'd5) begin
            sval <= neg_q ? -$signed(sin_mag) : $signed(sin_mag);
          end else begin
            t_q <= 31'(64'(rco_pkg::poly_const(step)) - (prod >>> 30));
          end
        end
        rco_pkg::ST_R29: r29 <= 32'((64'(a_q) << 15) - prod);
        rco_pkg::ST_XY: begin
          if (which == 2'd1) begin
            xin <= 32'(rco_pkg::rshr(prod, 21));
          end else begin
            yin <= 32'(rco_pkg::rshr(prod, 21));
          end
        end
        rco_pkg::ST_BQ: begin
          case (step)
            6'd0: yv <= rco_pkg::sat32(rco_pkg::rshr((64'(mem0[ch]) <<< 22) + prod, 22));
            6'd1: acc <= (64'(mem1[ch]) <<< 22) + prod;
            6'd3: acc <= prod;
            6'd4: begin
              if (ch) begin
                yo <= rco_pkg::sat16(rco_pkg::rshr(64'(yv), 8));
              end else begin
                xo <= rco_pkg::sat16(rco_pkg::rshr(64'(yv), 8));
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
